// File: rtl/lps_pkg.sv
// Shared types and constants for the LED pattern sequencer.
// Used by lps_step and led_pattern_sequencer_unit; depends on nothing else.
`timescale 1ns / 1ps

package lps_pkg;

  localparam int LED_STATE_W = 11;
  localparam int IN_DATA_W   = 64;
  localparam int OUT_DATA_W  = 16;

  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_START = 2'd1;
  localparam logic [1:0] FUNC_SET   = 2'd2;
  localparam logic [1:0] FUNC_CLEAR = 2'd3;

  localparam logic [2:0] MODE_IDLE = 3'd0;
  localparam logic [2:0] MODE_DIAL = 3'd1;
  localparam logic [2:0] MODE_CW   = 3'd2;
  localparam logic [2:0] MODE_CCW  = 3'd3;
  localparam logic [2:0] MODE_SHOW = 3'd4;

  localparam logic [1:0] REG_SLOW_BLINK  = 2'd0;
  localparam logic [1:0] REG_BOUNCE_STEP = 2'd1;
  localparam logic [1:0] REG_DIAL_STEP   = 2'd2;

  localparam logic [15:0] SLOW_BLINK_RESET  = 16'd350;
  localparam logic [15:0] BOUNCE_STEP_RESET = 16'd50;
  localparam logic [15:0] DIAL_STEP_RESET   = 16'd200;

  localparam logic signed [4:0] ROT_TOP     = 5'sd9;
  localparam logic signed [4:0] PH_BOUNCE   = 5'sd4;
  localparam logic signed [4:0] PH_BLINK2   = 5'sd12;
  localparam logic signed [4:0] SHOW_END    = 5'sd14;
  localparam logic signed [4:0] PH_MIN      = -5'sd1;

  typedef struct packed {
    logic [10:0] led_mask;
    logic [7:0]  pattern_data;
    logic [2:0]  pattern;
    logic        new_message;
    logic [31:0] now_ms;
    logic [1:0]  func;
  } lps_item_t;

  typedef struct packed {
    logic [15:0] slow_blink_ms;
    logic [15:0] bounce_step_ms;
    logic [15:0] dial_step_ms;
  } lps_cfg_t;

  typedef struct packed {
    logic               status;
    logic [2:0]         mode;
    logic [7:0]         arg;
    logic [31:0]        last_blink;
    logic [31:0]        last_dial;
    logic [8:0]         dial_pos;
    logic signed [4:0]  phase;
  } lps_ctx_t;

endpackage

// File: rtl/lps_step.sv
// Next-state logic of the LED pattern sequencer for one item.
// Pure combinational step; depends on lps_pkg.
`timescale 1ns / 1ps

module lps_step #(
  parameter int NUM_LEDS = 11
) (
  input  lps_pkg::lps_item_t   item,
  input  lps_pkg::lps_cfg_t    cfg,
  input  lps_pkg::lps_ctx_t    ctx,
  input  logic [NUM_LEDS-1:0]  leds,
  output lps_pkg::lps_ctx_t    ctx_next,
  output logic [NUM_LEDS-1:0]  leds_next
);
  import lps_pkg::*;

  logic [31:0]         diff_blink;
  logic [31:0]         diff_dial;
  logic [15:0]         blink_int;
  logic                in_bounce;
  logic                blink_due;
  logic                dial_due;
  logic signed [4:0]   rot_phase;
  logic [NUM_LEDS-1:0] rot_bits;
  logic [NUM_LEDS-1:0] dial_fill;
  logic [NUM_LEDS-1:0] show_fill;
  logic [NUM_LEDS-1:0] mask_n;
  logic [NUM_LEDS+10:0] mask_wide;
  logic [8:0]          dial_inc;

  assign in_bounce = (ctx.phase >= PH_BOUNCE) && (ctx.phase < PH_BLINK2);

  always_comb begin
    blink_int = cfg.slow_blink_ms;
    if (ctx.mode == MODE_CW || ctx.mode == MODE_CCW) begin
      blink_int = {8'd0, ctx.arg};
    end else if (ctx.mode == MODE_SHOW && in_bounce) begin
      blink_int = cfg.bounce_step_ms;
    end
  end

  assign diff_blink = item.now_ms - ctx.last_blink;
  assign diff_dial  = item.now_ms - ctx.last_dial;
  assign blink_due  = diff_blink > {16'd0, blink_int};
  assign dial_due   = diff_dial > {16'd0, cfg.dial_step_ms};
  assign dial_inc   = ctx.dial_pos + 9'd1;

  always_comb begin
    rot_phase = ctx.phase;
    if (ctx.mode == MODE_CW) begin
      if (ctx.phase < 5'sd0) begin
        rot_phase = ROT_TOP;
      end
    end else if (ctx.phase > ROT_TOP) begin
      rot_phase = 5'sd0;
    end
  end

  assign mask_wide = {{NUM_LEDS{1'b0}}, item.led_mask};
  assign mask_n    = mask_wide[NUM_LEDS-1:0];

  always_comb begin
    for (int i = 0; i < NUM_LEDS; i++) begin
      rot_bits[i]  = (rot_phase == 5'(i));
      show_fill[i] = (9'(i) <= ctx.dial_pos);
      if (i == 0) begin
        dial_fill[i] = leds[0];
      end else begin
        dial_fill[i] = (9'(i - 1) <= ctx.dial_pos);
      end
    end
  end

  always_comb begin
    ctx_next  = ctx;
    leds_next = leds;
    unique case (item.func)
      FUNC_TICK: begin
        unique case (ctx.mode)
          MODE_IDLE: begin
            if (item.new_message) begin
              if (blink_due) begin
                ctx_next.status     = ~ctx.status;
                ctx_next.last_blink = item.now_ms;
              end
            end else if (leds[0]) begin
              ctx_next.status = 1'b1;
            end
          end
          MODE_DIAL: begin
            leds_next = dial_fill;
            if (dial_due) begin
              ctx_next.last_dial = item.now_ms;
              if (dial_inc > {1'b0, ctx.arg}) begin
                ctx_next.dial_pos = 9'd0;
                ctx_next.mode     = MODE_IDLE;
                leds_next         = '0;
              end else begin
                ctx_next.dial_pos = dial_inc;
              end
            end
          end
          MODE_CW, MODE_CCW: begin
            ctx_next.phase = rot_phase;
            if (blink_due) begin
              ctx_next.last_blink = item.now_ms;
              leds_next           = rot_bits;
              if (ctx.mode == MODE_CW) begin
                ctx_next.phase = rot_phase - 5'sd1;
              end else begin
                ctx_next.phase = rot_phase + 5'sd1;
              end
            end
          end
          MODE_SHOW: begin
            if (ctx.phase < PH_BOUNCE || (ctx.phase >= PH_BLINK2 && ctx.phase < SHOW_END)) begin
              if (blink_due) begin
                ctx_next.last_blink = item.now_ms;
                leds_next           = ctx.phase[0] ? '0 : '1;
                ctx_next.phase      = ctx.phase + 5'sd1;
              end
            end else if (in_bounce) begin
              if (blink_due) begin
                ctx_next.last_blink = item.now_ms;
                leds_next           = show_fill;
                if (!ctx.phase[0]) begin
                  if (ctx.dial_pos == 9'(NUM_LEDS - 1)) begin
                    ctx_next.phase = ctx.phase + 5'sd1;
                  end else begin
                    ctx_next.dial_pos = dial_inc;
                  end
                end else begin
                  if (ctx.dial_pos == 9'd0) begin
                    ctx_next.phase = ctx.phase + 5'sd1;
                  end else begin
                    ctx_next.dial_pos = ctx.dial_pos - 9'd1;
                  end
                end
              end
            end else begin
              ctx_next.mode       = MODE_IDLE;
              ctx_next.arg        = 8'd0;
              ctx_next.last_blink = 32'd0;
              ctx_next.last_dial  = 32'd0;
              ctx_next.dial_pos   = 9'd0;
              ctx_next.phase      = 5'sd0;
            end
          end
          default: begin
          end
        endcase
      end
      FUNC_START: begin
        if (item.pattern <= MODE_SHOW) begin
          ctx_next.mode       = item.pattern;
          ctx_next.arg        = item.pattern_data;
          ctx_next.last_blink = 32'd0;
          ctx_next.last_dial  = 32'd0;
          ctx_next.dial_pos   = 9'd0;
          ctx_next.phase      = 5'sd0;
        end
      end
      FUNC_SET: begin
        leds_next = leds | mask_n;
      end
      FUNC_CLEAR: begin
        leds_next = leds & ~mask_n;
      end
    endcase
  end

endmodule

// File: rtl/led_pattern_sequencer_unit.sv
// Top level of the LED pattern sequencer: input register, state, result register.
// Depends on lps_pkg and lps_step.
`timescale 1ns / 1ps

// The block takes request beats on the s_ channel (tick, pattern start, mask set,
// mask clear) and returns exactly one result beat per request on the m_ channel,
// carrying the LED mask, the status pin level and the current mode.
// The cfg channel writes the three interval registers; it is always ready and
// must only be used while no request is in flight.
// A beat accepted on s_ is held in the input register; on the next cycle in which
// the result register is free or being drained, the single registered pass
// updates the state and loads the result register, which drives m_tvalid.
// Throughput is one beat per cycle while m_tready stays high; lps_step is combinational.
// When the receiver stalls, the result register holds its beat, the input register
// takes one more beat, and s_tready then drops until m_tready returns.
// Synchronous reset empties both registers, clears the mask, the status level
// and the mode state to idle, and loads the interval registers with 350, 50 and
// 200 ms.

module led_pattern_sequencer_unit #(
  parameter int NUM_LEDS = 11
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // func[1:0], now_ms[33:2], new_message[34], pattern[37:35],
  // pattern_data[45:38], led_mask[56:46], zero[63:57]
  input  logic [lps_pkg::IN_DATA_W-1:0]    s_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // led_state[10:0], status_pin[11], mode_now[14:12], zero[15]
  output logic [lps_pkg::OUT_DATA_W-1:0]   m_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [1:0]                       cfg_index,
  input  logic [15:0]                      cfg_data
);
  import lps_pkg::*;

  lps_cfg_t             cfg;
  lps_item_t            hold_item;
  logic                 hold_valid;
  lps_ctx_t             ctx;
  lps_ctx_t             ctx_next;
  logic [NUM_LEDS-1:0]  leds;
  logic [NUM_LEDS-1:0]  leds_next;
  logic [NUM_LEDS+10:0] leds_wide;
  logic                 out_valid;
  logic [OUT_DATA_W-1:0] out_data;
  logic                 advance;
  logic                 step_en;

  assign advance   = !out_valid || m_tready;
  assign step_en   = hold_valid && advance;
  assign s_tready  = !hold_valid || advance;
  assign cfg_ready = 1'b1;
  assign m_tvalid  = out_valid;
  assign m_tdata   = out_data;

  lps_step #(
    .NUM_LEDS(NUM_LEDS)
  ) u_step (
    .item      (hold_item),
    .cfg       (cfg),
    .ctx       (ctx),
    .leds      (leds),
    .ctx_next  (ctx_next),
    .leds_next (leds_next)
  );

  assign leds_wide = {{LED_STATE_W{1'b0}}, leds_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.slow_blink_ms  <= SLOW_BLINK_RESET;
      cfg.bounce_step_ms <= BOUNCE_STEP_RESET;
      cfg.dial_step_ms   <= DIAL_STEP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SLOW_BLINK: begin
          cfg.slow_blink_ms <= cfg_data;
        end
        REG_BOUNCE_STEP: begin
          cfg.bounce_step_ms <= cfg_data;
        end
        REG_DIAL_STEP: begin
          cfg.dial_step_ms <= cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      hold_valid <= 1'b1;
    end else if (step_en) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      hold_item <= lps_item_t'(s_tdata[56:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctx  <= '0;
      leds <= '0;
    end else if (step_en) begin
      ctx  <= ctx_next;
      leds <= leds_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step_en) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      out_data <= {1'b0, ctx_next.mode, ctx_next.status, leds_wide[LED_STATE_W-1:0]};
    end
  end

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !hold_valid |-> s_tready)
    else $error("input register empty but s_tready low");

  a_mode_legal: assert property (@(posedge clk) disable iff (rst)
    ctx.mode <= MODE_SHOW)
    else $error("mode register holds an undefined mode");

  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    ctx.phase >= PH_MIN && ctx.phase <= SHOW_END)
    else $error("phase counter out of range");

  a_dial_bound: assert property (@(posedge clk) disable iff (rst)
    ctx.mode == MODE_DIAL |-> ctx.dial_pos <= {1'b0, ctx.arg})
    else $error("dial position passed its limit without leaving dialer mode");

endmodule
